// ===== hw/rtl/abpp_pkg.sv =====
// Shared constants and types for the alpha blend / pixel pack block.
// No dependencies; every other file refers to this package by scoped name.
`timescale 1ns / 1ps

package abpp_pkg;

   // image size limit for incoming coordinates
   localparam int unsigned IMAGE_DIM = 4096;

   // field widths
   localparam int unsigned POS_W    = 12;
   localparam int unsigned SCREEN_W = 13;
   localparam int unsigned CHAN_W   = 8;
   localparam int unsigned LAYER_W  = 8;
   localparam int unsigned SHIFT_W  = 5;
   localparam int unsigned COLOR_W  = 32;
   localparam int unsigned PROD_W   = 2 * CHAN_W;

   // color channels carried through the datapath (red, green, blue)
   localparam int unsigned CHAN_COUNT = 3;

   // checkerboard greys
   localparam logic [PROD_W-1:0] GREY_LIGHT = 16'd255;
   localparam logic [PROD_W-1:0] GREY_DARK  = 16'd191;

   // bit of the coordinate that selects the checkerboard square
   localparam int unsigned CHECK_BIT = 4;

   // configuration port
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_PIXEL_FORMAT = 3'd0,
      REG_RED_SHIFT    = 3'd1,
      REG_GREEN_SHIFT  = 3'd2,
      REG_BLUE_SHIFT   = 3'd3,
      REG_ORIGIN_X     = 3'd4,
      REG_ORIGIN_Y     = 3'd5,
      REG_DRAW_LAYER   = 3'd6
   } reg_index_type;

   // pixel_format codes
   localparam logic FMT_XRGB32 = 1'b0;
   localparam logic FMT_RGB565 = 1'b1;

   // register reset values
   localparam logic [SHIFT_W-1:0] RED_SHIFT_RST   = 5'd16;
   localparam logic [SHIFT_W-1:0] GREEN_SHIFT_RST = 5'd8;
   localparam logic [SHIFT_W-1:0] BLUE_SHIFT_RST  = 5'd0;

endpackage

// ===== hw/rtl/alpha_blend_pixel_pack_core.sv =====
// Top level: five-stage blend-over-checkerboard and pixel pack pipeline
// with its APB-style register file. Depends on abpp_pkg.
`timescale 1ns / 1ps

//  channel   ports                         direction  transfer
//  request   start, busy, req_*            in         start && !busy
//  result    rsp_valid, rsp_*              out        rsp_valid, one cycle
//  config    psel, penable, pwrite, paddr  in/out     psel&&penable&&pwrite
//
// One pixel enters per clock; busy is low except during reset.
// rsp_valid rises once the result has passed the stages in order: register input
// and background term, multiply, add, divide by 255, pack.
// Reset clears the stage valid bits and restores the register defaults.
// The receiver cannot stall, so the pipeline advances on every clock.

module alpha_blend_pixel_pack_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // request
   input  logic                                  start,
   output logic                                  busy,
   input  logic [abpp_pkg::POS_W-1:0]            req_pos_x,
   input  logic [abpp_pkg::POS_W-1:0]            req_pos_y,
   input  logic [abpp_pkg::CHAN_W-1:0]           req_red_in,
   input  logic [abpp_pkg::CHAN_W-1:0]           req_green_in,
   input  logic [abpp_pkg::CHAN_W-1:0]           req_blue_in,
   input  logic [abpp_pkg::CHAN_W-1:0]           req_alpha_in,
   // result
   output logic                                  rsp_valid,
   output logic [abpp_pkg::SCREEN_W-1:0]         rsp_screen_x,
   output logic [abpp_pkg::SCREEN_W-1:0]         rsp_screen_y,
   output logic [abpp_pkg::LAYER_W-1:0]          rsp_pixel_layer,
   output logic [abpp_pkg::COLOR_W-1:0]          rsp_packed_color,
   // configuration
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [abpp_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [abpp_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [abpp_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                  pready
);

   // ------------------------------------------------------------------
   // register file
   // ------------------------------------------------------------------
   logic                               fmt_ff;
   logic [abpp_pkg::SHIFT_W-1:0]       red_shift_ff;
   logic [abpp_pkg::SHIFT_W-1:0]       green_shift_ff;
   logic [abpp_pkg::SHIFT_W-1:0]       blue_shift_ff;
   logic [abpp_pkg::POS_W-1:0]         origin_x_ff;
   logic [abpp_pkg::POS_W-1:0]         origin_y_ff;
   logic [abpp_pkg::LAYER_W-1:0]       layer_ff;
   logic                               csr_write;
   abpp_pkg::reg_index_type            csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = abpp_pkg::reg_index_type'(paddr[abpp_pkg::CSR_ADDR_W-1:2]);

   // update one register per write transfer, ignore unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff         <= abpp_pkg::FMT_XRGB32;
         red_shift_ff   <= abpp_pkg::RED_SHIFT_RST;
         green_shift_ff <= abpp_pkg::GREEN_SHIFT_RST;
         blue_shift_ff  <= abpp_pkg::BLUE_SHIFT_RST;
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
         layer_ff       <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            abpp_pkg::REG_PIXEL_FORMAT: fmt_ff         <= pwdata[0];
            abpp_pkg::REG_RED_SHIFT:    red_shift_ff   <= pwdata[abpp_pkg::SHIFT_W-1:0];
            abpp_pkg::REG_GREEN_SHIFT:  green_shift_ff <= pwdata[abpp_pkg::SHIFT_W-1:0];
            abpp_pkg::REG_BLUE_SHIFT:   blue_shift_ff  <= pwdata[abpp_pkg::SHIFT_W-1:0];
            abpp_pkg::REG_ORIGIN_X:     origin_x_ff    <= pwdata[abpp_pkg::POS_W-1:0];
            abpp_pkg::REG_ORIGIN_Y:     origin_y_ff    <= pwdata[abpp_pkg::POS_W-1:0];
            abpp_pkg::REG_DRAW_LAYER:   layer_ff       <= pwdata[abpp_pkg::LAYER_W-1:0];
            default: ;
         endcase
      end
   end

   // read back the addressed register
   always_comb begin
      prdata = '0;
      unique case (csr_index)
         abpp_pkg::REG_PIXEL_FORMAT: prdata = abpp_pkg::CSR_DATA_W'(fmt_ff);
         abpp_pkg::REG_RED_SHIFT:    prdata = abpp_pkg::CSR_DATA_W'(red_shift_ff);
         abpp_pkg::REG_GREEN_SHIFT:  prdata = abpp_pkg::CSR_DATA_W'(green_shift_ff);
         abpp_pkg::REG_BLUE_SHIFT:   prdata = abpp_pkg::CSR_DATA_W'(blue_shift_ff);
         abpp_pkg::REG_ORIGIN_X:     prdata = abpp_pkg::CSR_DATA_W'(origin_x_ff);
         abpp_pkg::REG_ORIGIN_Y:     prdata = abpp_pkg::CSR_DATA_W'(origin_y_ff);
         abpp_pkg::REG_DRAW_LAYER:   prdata = abpp_pkg::CSR_DATA_W'(layer_ff);
         default:                    prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // stage 1: qualify the transfer, place it, form the background term
   // ------------------------------------------------------------------
   logic                                                  accept;
   logic                                                  in_image;
   logic                                                  light_sq;
   logic [abpp_pkg::CHAN_W-1:0]                           inv_alpha;
   logic [abpp_pkg::PROD_W-1:0]                           grey;
   logic [abpp_pkg::CHAN_COUNT-1:0][abpp_pkg::CHAN_W-1:0] chan_in;

   logic                                                  s1_valid_ff, s1_valid_in;
   logic [abpp_pkg::CHAN_W-1:0]                           s1_alpha_ff;
   logic [abpp_pkg::CHAN_COUNT-1:0][abpp_pkg::CHAN_W-1:0] s1_chan_ff;
   logic [abpp_pkg::PROD_W-1:0]                           s1_bg_ff, s1_bg_in;
   logic [abpp_pkg::SCREEN_W-1:0]                         s1_sx_ff, s1_sx_in;
   logic [abpp_pkg::SCREEN_W-1:0]                         s1_sy_ff, s1_sy_in;

   assign busy   = reset;
   assign accept = start && !busy;

   assign chan_in = {req_blue_in, req_green_in, req_red_in};

   always_comb begin
      in_image    = (32'(req_pos_x) < 32'(abpp_pkg::IMAGE_DIM))
                 && (32'(req_pos_y) < 32'(abpp_pkg::IMAGE_DIM));
      s1_valid_in = accept && (req_alpha_in != '0) && in_image;
      light_sq    = req_pos_x[abpp_pkg::CHECK_BIT] == req_pos_y[abpp_pkg::CHECK_BIT];
      grey        = light_sq ? abpp_pkg::GREY_LIGHT : abpp_pkg::GREY_DARK;
      inv_alpha   = ~req_alpha_in;
      s1_bg_in    = abpp_pkg::PROD_W'(abpp_pkg::PROD_W'(inv_alpha) * grey);
      s1_sx_in    = abpp_pkg::SCREEN_W'(origin_x_ff) + abpp_pkg::SCREEN_W'(req_pos_x);
      s1_sy_in    = abpp_pkg::SCREEN_W'(origin_y_ff) + abpp_pkg::SCREEN_W'(req_pos_y);
   end

   // ------------------------------------------------------------------
   // stage 2: alpha times channel
   // ------------------------------------------------------------------
   logic                                                  s2_valid_ff;
   logic [abpp_pkg::CHAN_COUNT-1:0][abpp_pkg::PROD_W-1:0] s2_prod_ff, s2_prod_in;
   logic [abpp_pkg::PROD_W-1:0]                           s2_bg_ff;
   logic [abpp_pkg::SCREEN_W-1:0]                         s2_sx_ff, s2_sy_ff;

   always_comb begin
      for (int i = 0; i < abpp_pkg::CHAN_COUNT; i++) begin
         s2_prod_in[i] = abpp_pkg::PROD_W'(s1_alpha_ff) * abpp_pkg::PROD_W'(s1_chan_ff[i]);
      end
   end

   // ------------------------------------------------------------------
   // stage 3: add background term (at most 255*255, fits 16 bits)
   // ------------------------------------------------------------------
   logic                                                  s3_valid_ff;
   logic [abpp_pkg::CHAN_COUNT-1:0][abpp_pkg::PROD_W-1:0] s3_sum_ff, s3_sum_in;
   logic [abpp_pkg::SCREEN_W-1:0]                         s3_sx_ff, s3_sy_ff;

   always_comb begin
      for (int i = 0; i < abpp_pkg::CHAN_COUNT; i++) begin
         s3_sum_in[i] = s2_prod_ff[i] + s2_bg_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 4: divide by 255 as (v + (v >> 8) + 1) >> 8, exact for v up to
   // 65534; the sums never exceed 65025
   // ------------------------------------------------------------------
   logic                                                  s4_valid_ff;
   logic [abpp_pkg::CHAN_COUNT-1:0][abpp_pkg::CHAN_W-1:0] s4_chan_ff, s4_chan_in;
   logic [abpp_pkg::CHAN_COUNT-1:0][abpp_pkg::PROD_W:0]   quot_sum;
   logic [abpp_pkg::SCREEN_W-1:0]                         s4_sx_ff, s4_sy_ff;

   always_comb begin
      for (int i = 0; i < abpp_pkg::CHAN_COUNT; i++) begin
         quot_sum[i]   = (abpp_pkg::PROD_W+1)'(s3_sum_ff[i])
                       + (abpp_pkg::PROD_W+1)'(s3_sum_ff[i][abpp_pkg::PROD_W-1:abpp_pkg::CHAN_W])
                       + (abpp_pkg::PROD_W+1)'(1);
         s4_chan_in[i] = quot_sum[i][abpp_pkg::PROD_W-1:abpp_pkg::CHAN_W];
      end
   end

   // ------------------------------------------------------------------
   // stage 5: pack the colour into the output register
   // ------------------------------------------------------------------
   logic                                       out_valid_ff;
   logic [abpp_pkg::COLOR_W-1:0]               out_color_ff, out_color_in;
   logic [abpp_pkg::SCREEN_W-1:0]              out_sx_ff, out_sy_ff;
   logic [abpp_pkg::LAYER_W-1:0]               out_layer_ff;
   logic [abpp_pkg::CHAN_W-1:0]                pk_r, pk_g, pk_b;

   always_comb begin
      pk_r = s4_chan_ff[0];
      pk_g = s4_chan_ff[1];
      pk_b = s4_chan_ff[2];
      if (fmt_ff == abpp_pkg::FMT_RGB565) begin
         out_color_in = abpp_pkg::COLOR_W'({pk_r[7:3], pk_g[7:2], pk_b[7:3]});
      end else begin
         // drop bits shifted past the top; overlapping channels OR together
         out_color_in = (abpp_pkg::COLOR_W'(pk_r) << red_shift_ff)
                      | (abpp_pkg::COLOR_W'(pk_g) << green_shift_ff)
                      | (abpp_pkg::COLOR_W'(pk_b) << blue_shift_ff);
      end
   end

   // advance the valid bits every clock
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         out_valid_ff <= s4_valid_ff;
      end
   end

   // advance the payload alongside
   always_ff @(posedge clock) begin
      s1_alpha_ff  <= req_alpha_in;
      s1_chan_ff   <= chan_in;
      s1_bg_ff     <= s1_bg_in;
      s1_sx_ff     <= s1_sx_in;
      s1_sy_ff     <= s1_sy_in;

      s2_prod_ff   <= s2_prod_in;
      s2_bg_ff     <= s1_bg_ff;
      s2_sx_ff     <= s1_sx_ff;
      s2_sy_ff     <= s1_sy_ff;

      s3_sum_ff    <= s3_sum_in;
      s3_sx_ff     <= s2_sx_ff;
      s3_sy_ff     <= s2_sy_ff;

      s4_chan_ff   <= s4_chan_in;
      s4_sx_ff     <= s3_sx_ff;
      s4_sy_ff     <= s3_sy_ff;

      out_color_ff <= out_color_in;
      out_sx_ff    <= s4_sx_ff;
      out_sy_ff    <= s4_sy_ff;
      out_layer_ff <= layer_ff;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_screen_x     = out_sx_ff;
   assign rsp_screen_y     = out_sy_ff;
   assign rsp_pixel_layer  = out_layer_ff;
   assign rsp_packed_color = out_color_ff;

endmodule

// ===== hw/rtl/abpp_checker.sv =====
// Port-level checker for alpha_blend_pixel_pack_core, bound to the top level.
// Depends on abpp_pkg and on the top level's port list.
`timescale 1ns / 1ps

module abpp_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  start,
   input logic                                  busy,
   input logic [abpp_pkg::POS_W-1:0]            req_pos_x,
   input logic [abpp_pkg::POS_W-1:0]            req_pos_y,
   input logic [abpp_pkg::CHAN_W-1:0]           req_alpha_in,
   input logic                                  rsp_valid,
   input logic [abpp_pkg::SCREEN_W-1:0]         rsp_screen_x,
   input logic [abpp_pkg::SCREEN_W-1:0]         rsp_screen_y,
   input logic                                  psel,
   input logic                                  pready
);

   logic visible;

   // a transfer that must yield a result
   assign visible = start && !busy && (req_alpha_in != '0)
                 && (32'(req_pos_x) < 32'(abpp_pkg::IMAGE_DIM))
                 && (32'(req_pos_y) < 32'(abpp_pkg::IMAGE_DIM));

   // every visible pixel is followed by a result on rsp_valid
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      visible |-> ##5 rsp_valid)
      else $error("visible pixel produced no result");

   // no result without an earlier visible pixel
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(visible, 5))
      else $error("result without a matching transfer");

   // screen position never falls below the image position
   a_screen_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_screen_x >= abpp_pkg::SCREEN_W'($past(req_pos_x, 5)))
                 && (rsp_screen_y >= abpp_pkg::SCREEN_W'($past(req_pos_y, 5))))
      else $error("screen position below image position");

   // register port never inserts wait states
   a_pready: assert property (@(posedge clock) disable iff (reset)
      psel |-> pready)
      else $error("pready low during a register transfer");

endmodule

bind alpha_blend_pixel_pack_core abpp_checker u_abpp_checker (.*);
